/* src/deq_pkg.sv */
package deq_pkg;

  // Ring geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 64;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Add an offset of at most DEPTH to a ring index, wrapping once
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

/* src/deq_ram.sv */
module deq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/double_ended_queue.sv */
// Bounded double-ended queue of 64-bit signed values in a 16-slot ring held in
// one synchronous RAM. A push, or any failed pop/list, is taken and its result
// goes straight into the result register, so pushes run one per cycle while
// that register is not stalled. A pop or a list reads the RAM through its
// single registered read port: the read index and count are registered, then
// the RAM read data, then the result register; list entries follow one per
// cycle while the result register is not stalled. New items are held off
// (in_stall_o) while a read job runs or while the result register is full and
// stalled. Codes 5 to 7 are taken and dropped.
module double_ended_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    operation_i,
  input  logic signed [63:0]            value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic signed [63:0]            value_res_o,
  output logic                          last_o
);
  import deq_pkg::*;

  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              rd_q, rd_d;
  logic              rd_last_q, rd_last_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        status_q, status_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              last_q, last_d;

  logic              out_free, busy, accept, issue;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] rdata;
  op_e               op;

  assign op       = op_e'(operation_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign busy     = rd_q || (rd_cnt_q != '0);
  assign in_stall_o = busy || !out_free;
  assign accept   = in_valid_i && !in_stall_o;
  assign issue    = (rd_cnt_q != '0) && (!rd_q || out_free);

  deq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (issue),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  // Decode items, run read jobs, load the result register
  always_comb begin
    head_d      = head_q;
    occ_d       = occ_q;
    rd_idx_d    = rd_idx_q;
    rd_cnt_d    = rd_cnt_q;
    rd_d        = rd_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    value_d     = value_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = head_q;

    // Advance the read job
    if (issue) begin
      rd_idx_d  = ring_add(rd_idx_q, CNT_W'(1));
      rd_cnt_d  = rd_cnt_q - 1'b1;
      rd_last_d = (rd_cnt_q == CNT_W'(1));
    end
    if (rd_q && out_free) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      value_d     = rdata;
      last_d      = rd_last_q;
    end
    if (issue) begin
      rd_d = 1'b1;
    end else if (rd_q && out_free) begin
      rd_d = 1'b0;
    end

    // Take a new item
    if (accept) begin
      case (op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          out_valid_d = 1'b1;
          value_d     = '0;
          last_d      = 1'b1;
          if (occ_q == FULL_CNT) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_OK;
            we       = 1'b1;
            occ_d    = occ_q + 1'b1;
            if (op == OP_PUSH_FRONT) begin
              head_d = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
              waddr  = head_d;
            end else begin
              waddr = ring_add(head_q, occ_q);
            end
          end
        end
        OP_POP_FRONT, OP_POP_REAR, OP_LIST: begin
          if (occ_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = ST_EMPTY;
            value_d     = '0;
            last_d      = 1'b1;
          end else if (op == OP_POP_FRONT) begin
            rd_idx_d = head_q;
            rd_cnt_d = CNT_W'(1);
            head_d   = ring_add(head_q, CNT_W'(1));
            occ_d    = occ_q - 1'b1;
          end else if (op == OP_POP_REAR) begin
            rd_idx_d = ring_add(head_q, occ_q - 1'b1);
            rd_cnt_d = CNT_W'(1);
            occ_d    = occ_q - 1'b1;
          end else begin
            rd_idx_d = head_q;
            rd_cnt_d = occ_q;
          end
        end
        default: begin
          // Drop undefined operation codes
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      occ_q       <= '0;
      rd_cnt_q    <= '0;
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      occ_q       <= occ_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    rd_last_q <= rd_last_d;
    status_q  <= status_d;
    value_q   <= value_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_res_o = value_q;
  assign last_o      = last_q;

  // Occupancy stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= FULL_CNT)
    else $error("occupancy beyond depth");

  // A read job never outgrows the stored entries plus the one a pop just removed
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_cnt_q <= occ_q + 1'b1)
    else $error("read job longer than queue");

  // Read data waiting on a stalled result register is kept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q && !out_free |=> rd_q)
    else $error("pending read data lost");

  // The final read of a job is marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && rd_cnt_q == CNT_W'(1) |=> rd_q && rd_last_q)
    else $error("last read not marked");

endmodule
